// ===== rtl/tpq_pkg.sv =====
// tpq_pkg: shared types, codes and constants of the touch pad qualifier
// depends on nothing; imported by the interfaces, tpq_mean_div and the top level
package tpq_pkg;

    localparam int OPCODE_W   = 2;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int SIZE_W     = 3;
    localparam int HOLD_W     = 2;
    localparam int DIV_BITS   = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CALIB = 2'd0,
        OP_SCAN  = 2'd1,
        OP_REARM = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_SIZE = 2'd0,
        CFG_LONG_SIZE  = 2'd1,
        CFG_HOLD_SCANS = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_CALIB = 1'b0,
        KIND_SCAN  = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        CAL_IDLE,
        CAL_SUM,
        CAL_DIV,
        CAL_LOAD
    } cal_state_t;

    localparam logic [SIZE_W-1:0] SHORT_SIZE_RST = 3'd3;
    localparam logic [SIZE_W-1:0] LONG_SIZE_RST  = 3'd6;
    localparam logic [HOLD_W-1:0] HOLD_SCANS_RST = 2'd3;

    // samples above threshold needed for a valid group: floor(size*2/3)
    function automatic logic [SIZE_W-1:0] need_count(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] need;
        case (size)
            3'd0:    need = 3'd0;
            3'd1:    need = 3'd0;
            3'd2:    need = 3'd1;
            3'd3:    need = 3'd2;
            3'd4:    need = 3'd2;
            3'd5:    need = 3'd3;
            3'd6:    need = 3'd4;
            3'd7:    need = 3'd4;
            default: need = 3'd0;
        endcase
        return need;
    endfunction

endpackage

// ===== rtl/tpq_ifs.sv =====
// tpq_ifs: valid/ready channel interfaces of the touch pad qualifier
// depends on tpq_pkg for field widths
interface tpq_sample_if import tpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SAMPLE_W-1:0] charge_time;

    modport source (output valid, opcode, charge_time, input ready);
    modport sink   (input valid, opcode, charge_time, output ready);
endinterface

interface tpq_result_if import tpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic                pressed;
    logic [SAMPLE_W-1:0] group_value;
    logic [SAMPLE_W-1:0] baseline_out;
    logic                calib_fault;

    modport source (output valid, result_kind, pressed, group_value, baseline_out,
                    calib_fault, input ready);
    modport sink   (input valid, result_kind, pressed, group_value, baseline_out,
                    calib_fault, output ready);
endinterface

interface tpq_cfg_if import tpq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tpq_sort_cell.sv =====
// tpq_sort_cell: one rank of the insertion sorter, holds one calibration sample
// no package dependencies; instantiated by tpq_sort_chain
module tpq_sort_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic                   occupied,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] left_value,
    input  logic                   left_below,
    output logic [SAMPLE_BITS-1:0] value,
    output logic                   below
);

    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;

    // new sample lands at or left of this rank: empty ranks count as +inf
    assign below = !occupied || (sample < value_reg);

    always_comb
    begin
        if (below)
        begin
            value_next = left_below ? left_value : sample;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/tpq_sort_chain.sv =====
// tpq_sort_chain: row of sort cells plus fill count and trimmed sum of the middle ranks
// depends on tpq_sort_cell; instantiated by the top level
module tpq_sort_chain #(
    parameter int CAL_SAMPLES = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          last,
    output logic [SAMPLE_BITS+$clog2((CAL_SAMPLES*3)/5 < 1 ? 1 : (CAL_SAMPLES*3)/5)-1:0]
                                          kept_sum
);

    localparam int KEEP_RAW = (CAL_SAMPLES * 3) / 5;
    localparam int KEEP     = (KEEP_RAW < 1) ? 1 : KEEP_RAW;
    localparam int TRIM     = (CAL_SAMPLES - KEEP) / 2;
    localparam int CNT_W    = $clog2(CAL_SAMPLES);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(KEEP);

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [SAMPLE_BITS-1:0] cell_value [CAL_SAMPLES];
    logic                   cell_below [CAL_SAMPLES];
    logic [SAMPLE_BITS-1:0] left_value [CAL_SAMPLES];
    logic                   left_below [CAL_SAMPLES];
    logic [SUM_W-1:0]       sum;

    assign last = (count_reg == CNT_W'(CAL_SAMPLES - 1));

    always_comb
    begin
        count_next = count_reg;
        if (wr_en)
        begin
            count_next = last ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < CAL_SAMPLES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_value[i] = sample;
            assign left_below[i] = 1'b0;
        end
        else
        begin : g_link
            assign left_value[i] = cell_value[i-1];
            assign left_below[i] = cell_below[i-1];
        end

        tpq_sort_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk        (clk),
            .wr_en      (wr_en),
            .occupied   (CNT_W'(i) < count_reg),
            .sample     (sample),
            .left_value (left_value[i]),
            .left_below (left_below[i]),
            .value      (cell_value[i]),
            .below      (cell_below[i])
        );
    end

    // middle ranks only, extremes trimmed
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < KEEP; k++)
        begin
            sum = sum + SUM_W'(cell_value[TRIM + k]);
        end
    end

    assign kept_sum = sum;

endmodule

// ===== rtl/tpq_mean_div.sv =====
// tpq_mean_div: restoring divider by a fixed count, DIV_BITS quotient bits per cycle
// depends on tpq_pkg; instantiated by the top level
module tpq_mean_div import tpq_pkg::*; #(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR    = 6,
    parameter int QUOT_W     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int DIV_W  = ((DIVIDEND_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int STEPS  = DIV_W / DIV_BITS;
    localparam int STEP_W = $clog2(STEPS + 1);
    localparam int REM_W  = $clog2(DIVISOR) + 1;

    logic [DIV_W-1:0]  dq_reg;
    logic [DIV_W-1:0]  dq_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [REM_W-1:0]  trial;
    logic [STEP_W-1:0] steps_reg;
    logic              run_reg;

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_comb
    begin
        dq_next  = dq_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            trial   = {rem_next[REM_W-2:0], dq_next[DIV_W-1]};
            dq_next = {dq_next[DIV_W-2:0], 1'b0};
            if (trial >= REM_W'(DIVISOR))
            begin
                rem_next   = trial - REM_W'(DIVISOR);
                dq_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= DIV_W'(dividend);
            rem_reg <= '0;
        end
        else if (steps_reg != '0)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            run_reg   <= 1'b0;
        end
        else if (start)
        begin
            steps_reg <= STEP_W'(STEPS);
            run_reg   <= 1'b1;
        end
        else if (steps_reg != '0)
        begin
            steps_reg <= steps_reg - 1'b1;
        end
        else
        begin
            run_reg <= 1'b0;
        end
    end

    assign done     = run_reg && (steps_reg == '0);
    assign quotient = dq_reg[QUOT_W-1:0];

endmodule

// ===== rtl/touch_pad_qualifier_core.sv =====
// touch_pad_qualifier_core: top level of the capacitive touch key qualifier
// depends on tpq_pkg, tpq_ifs, tpq_sort_chain, tpq_sort_cell and tpq_mean_div
//
//   channel   dir  modport         payload
//   samples   in   tpq_sample_if   opcode, charge_time
//   results   out  tpq_result_if   result_kind, pressed, group_value, baseline_out,
//                                  calib_fault
//   cfg       in   tpq_cfg_if      index, data (always ready)
//
// one word per cycle on samples, back to back, scan and calibration alike
// the word that completes a calibration set holds samples off while the trimmed sum
//   is divided and the new baseline loaded (CAL_SUM, CAL_DIV, CAL_LOAD); the sum is
//   SUM_W = SAMPLE_BITS + clog2(keep count) bits wide
// a scan result is registered in the group stage, then in the result register
// results stalled: the group stage still takes a word, then samples.ready drops
// rst_n clears counts, baseline, lockout and valid flags; sort cells hold no reset
module touch_pad_qualifier_core import tpq_pkg::*; #(
    parameter int CAL_SAMPLES = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    tpq_sample_if.sink         samples,
    tpq_result_if.source       results,
    tpq_cfg_if.sink            cfg
);

    localparam int KEEP_RAW = (CAL_SAMPLES * 3) / 5;
    localparam int KEEP     = (KEEP_RAW < 1) ? 1 : KEEP_RAW;
    localparam int SUM_W    = SAMPLE_BITS + $clog2(KEEP);
    // thresholds are compared on scaled values: 4x vs 5b, 3v vs 4b, v vs 10b
    localparam int THR_W    = SAMPLE_BITS + 4;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] short_size_reg;
    logic [SIZE_W-1:0] long_size_reg;
    logic [HOLD_W-1:0] hold_scans_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_size_reg <= SHORT_SIZE_RST;
            long_size_reg  <= LONG_SIZE_RST;
            hold_scans_reg <= HOLD_SCANS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SHORT_SIZE: short_size_reg <= cfg.data[SIZE_W-1:0];
                CFG_LONG_SIZE:  long_size_reg  <= cfg.data[SIZE_W-1:0];
                CFG_HOLD_SCANS: hold_scans_reg <= cfg.data[HOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    logic                   in_ready;
    logic                   accept;
    logic                   is_calib;
    logic                   is_scan;
    logic                   is_rearm;
    logic [SAMPLE_BITS-1:0] x;

    assign samples.ready = in_ready;
    assign accept        = samples.valid && in_ready;
    assign is_calib      = (samples.opcode == OP_CALIB);
    assign is_scan       = (samples.opcode == OP_SCAN);
    assign is_rearm      = (samples.opcode == OP_REARM);
    assign x             = SAMPLE_BITS'(samples.charge_time);

    // ------------------------------------------------------------------
    // calibration: sorter chain and mean divider
    // ------------------------------------------------------------------
    logic                   sort_last;
    logic [SUM_W-1:0]       kept_sum;
    logic                   div_start;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] div_quot;

    tpq_sort_chain #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sort (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && is_calib),
        .sample   (x),
        .last     (sort_last),
        .kept_sum (kept_sum)
    );

    tpq_mean_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (KEEP),
        .QUOT_W     (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (kept_sum),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // calibration sequencer
    // ------------------------------------------------------------------
    cal_state_t cal_state_reg;
    cal_state_t cal_state_next;
    logic       p_free;
    logic       cal_inject;

    always_comb
    begin
        cal_state_next = cal_state_reg;
        case (cal_state_reg)
            CAL_IDLE:
            begin
                if (accept && is_calib && sort_last)
                begin
                    cal_state_next = CAL_SUM;
                end
            end
            CAL_SUM:  cal_state_next = CAL_DIV;
            CAL_DIV:
            begin
                if (div_done)
                begin
                    cal_state_next = CAL_LOAD;
                end
            end
            CAL_LOAD:
            begin
                if (p_free)
                begin
                    cal_state_next = CAL_IDLE;
                end
            end
            default:  cal_state_next = CAL_IDLE;
        endcase
    end

    // samples wait while a new baseline is on its way or the group stage is full
    always_comb
    begin
        in_ready   = 1'b0;
        div_start  = 1'b0;
        cal_inject = 1'b0;
        case (cal_state_reg)
            CAL_IDLE: in_ready   = p_free;
            CAL_SUM:  div_start  = 1'b1;
            CAL_DIV:  ;
            CAL_LOAD: cal_inject = p_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_state_reg <= CAL_IDLE;
        end
        else
        begin
            cal_state_reg <= cal_state_next;
        end
    end

    // ------------------------------------------------------------------
    // baseline and derived thresholds, updated as the calibration word
    // enters the group stage so earlier scan results keep the old value
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] baseline_reg;
    logic [THR_W-1:0]       valid_thr_reg;
    logic [THR_W-1:0]       press_lo_reg;
    logic [THR_W-1:0]       press_hi_reg;
    logic [THR_W-1:0]       quot_ext;

    assign quot_ext = THR_W'(div_quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            valid_thr_reg <= '0;
            press_lo_reg  <= '0;
            press_hi_reg  <= '0;
        end
        else if (cal_inject)
        begin
            baseline_reg  <= div_quot;
            valid_thr_reg <= (quot_ext << 2) + quot_ext;
            press_lo_reg  <= quot_ext << 2;
            press_hi_reg  <= (quot_ext << 3) + (quot_ext << 1);
        end
    end

    // ------------------------------------------------------------------
    // scan group accumulation, on the accepted word
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]      group_count_reg;
    logic [SIZE_W-1:0]      group_target_reg;
    logic [SIZE_W-1:0]      valid_count_reg;
    logic [SAMPLE_BITS-1:0] group_peak_reg;

    logic                   grp_start;
    logic [SIZE_W-1:0]      size_sel;
    logic [SIZE_W-1:0]      size_eff;
    logic [SIZE_W-1:0]      tgt;
    logic [SIZE_W-1:0]      gc_base;
    logic [SIZE_W-1:0]      vc_base;
    logic [SAMPLE_BITS-1:0] pk_base;
    logic                   above;
    logic [SIZE_W-1:0]      gc_next;
    logic [SIZE_W-1:0]      vc_next;
    logic [SAMPLE_BITS-1:0] pk_next;
    logic                   grp_end;
    logic [SAMPLE_BITS-1:0] grp_val;
    logic                   scan_take;

    always_comb
    begin
        grp_start = is_rearm || (group_count_reg == '0);
        size_sel  = is_rearm ? long_size_reg : short_size_reg;
        // a zero size acts as one
        size_eff  = (size_sel == '0) ? SIZE_W'(1) : size_sel;
        tgt       = grp_start ? size_eff : group_target_reg;
        gc_base   = grp_start ? '0 : group_count_reg;
        vc_base   = grp_start ? '0 : valid_count_reg;
        pk_base   = grp_start ? '0 : group_peak_reg;
        // x > floor(5b/4)  <=>  4x > 5b
        above     = (THR_W'(x) << 2) > valid_thr_reg;
        gc_next   = gc_base + 1'b1;
        vc_next   = vc_base + SIZE_W'(above);
        pk_next   = (x > pk_base) ? x : pk_base;
        grp_end   = (gc_next >= tgt);
        grp_val   = (vc_next >= need_count(tgt)) ? pk_next : '0;
    end

    assign scan_take = accept && (is_scan || is_rearm);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg  <= '0;
            group_target_reg <= '0;
            valid_count_reg  <= '0;
            group_peak_reg   <= '0;
        end
        else if (scan_take)
        begin
            group_target_reg <= tgt;
            if (grp_end)
            begin
                group_count_reg <= '0;
                valid_count_reg <= '0;
                group_peak_reg  <= '0;
            end
            else
            begin
                group_count_reg <= gc_next;
                valid_count_reg <= vc_next;
                group_peak_reg  <= pk_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // group stage: finished groups, re-arms and the calibration word,
    // kept in order so the lockout sees them as they arrived
    // ------------------------------------------------------------------
    logic                   p_valid_reg;
    logic                   p_kind_reg;
    logic                   p_rearm_reg;
    logic                   p_end_reg;
    logic [SAMPLE_BITS-1:0] p_val_reg;
    logic                   p_load;
    logic                   p_out;
    logic                   p_adv;
    logic                   o_free;

    logic                   o_valid_reg;
    logic                   o_kind_reg;
    logic                   o_pressed_reg;
    logic [SAMPLE_BITS-1:0] o_val_reg;
    logic [SAMPLE_BITS-1:0] o_base_reg;
    logic                   o_fault_reg;

    assign o_free = !o_valid_reg || results.ready;
    assign p_out  = (p_kind_reg == KIND_CALIB) || p_end_reg;
    // a re-arm with no finished group only clears the lockout
    assign p_adv  = p_valid_reg && (!p_out || o_free);
    assign p_free = !p_valid_reg || p_adv;
    assign p_load = cal_inject || (scan_take && (is_rearm || grp_end));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (p_load)
        begin
            p_valid_reg <= 1'b1;
        end
        else if (p_adv)
        begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            p_kind_reg  <= cal_inject ? KIND_CALIB : KIND_SCAN;
            p_rearm_reg <= !cal_inject && is_rearm;
            p_end_reg   <= !cal_inject && grp_end;
            p_val_reg   <= grp_val;
        end
    end

    // ------------------------------------------------------------------
    // press decision and hold lockout
    // ------------------------------------------------------------------
    logic [HOLD_W-1:0] lockout_reg;
    logic [HOLD_W-1:0] lk_base;
    logic [HOLD_W-1:0] lk_load;
    logic [HOLD_W-1:0] lk_next;
    logic [THR_W-1:0]  val_ext;
    logic              in_range;
    logic              press;

    always_comb
    begin
        lk_base  = p_rearm_reg ? '0 : lockout_reg;
        val_ext  = THR_W'(p_val_reg);
        // v > floor(4b/3)  <=>  3v > 4b
        in_range = (((val_ext << 1) + val_ext) > press_lo_reg) && (val_ext < press_hi_reg);
        press    = in_range && (lk_base == '0);
        lk_load  = in_range ? hold_scans_reg : lk_base;
        lk_next  = (lk_load != '0) ? lk_load - 1'b1 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg <= '0;
        end
        else if (p_adv && (p_kind_reg == KIND_SCAN))
        begin
            lockout_reg <= p_end_reg ? lk_next : lk_base;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (p_adv && p_out)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_adv && p_out)
        begin
            o_kind_reg    <= p_kind_reg;
            o_pressed_reg <= (p_kind_reg == KIND_SCAN) && press;
            o_val_reg     <= (p_kind_reg == KIND_SCAN) ? p_val_reg : '0;
            o_base_reg    <= baseline_reg;
            // at or above half of full scale means the top bit is set
            o_fault_reg   <= baseline_reg[SAMPLE_BITS-1];
        end
    end

    assign results.valid        = o_valid_reg;
    assign results.result_kind  = o_kind_reg;
    assign results.pressed      = o_pressed_reg;
    assign results.group_value  = SAMPLE_W'(o_val_reg);
    assign results.baseline_out = SAMPLE_W'(o_base_reg);
    assign results.calib_fault  = o_fault_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_cal_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_calib && sort_last) |=> (cal_state_reg == CAL_SUM))
        else $error("completed calibration set did not start the mean");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (cal_state_reg == CAL_DIV))
        else $error("divider finished outside the divide phase");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && p_out && o_valid_reg && !results.ready) |-> !samples.ready)
        else $error("sample taken with both result stages blocked");

    a_inject_order: assert property (@(posedge clk) disable iff (!rst_n)
        cal_inject |-> !(scan_take))
        else $error("scan word taken while calibration result enters the pipe");

endmodule
